// ----- hw/rtl/ffra_pkg.sv -----
package ffra_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  // rectangle and grid sizes, result coordinates
  localparam int DIM_W = 7;
  localparam int POS_W = 6;

  localparam logic [DIM_W-1:0] GRID_RESET = 7'd64;

  localparam int CFG_IDX_W  = 1;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_ROWS = 1'b0,
    REG_GRID_COLS = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic clear;
    logic load;
    logic scan;
    logic mark_load;
    logic mark;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic reject;
    logic hit;
    logic scan_done;
    logic mark_done;
  } ctrl_stat_t;

endpackage

// ----- hw/rtl/first_fit_rect_allocator_unit.sv -----
// First-fit rectangle allocator over an occupancy bitmap of MAX_ROWS x MAX_COLS cells, of
// which grid_rows x grid_cols are in use (register 0 and 1 on the cfg port, reset 64 each,
// values above the maximum saturate). A request of rect_rows x rect_cols cells takes the
// first free origin in row-major order, marks its cells and returns found, row and column;
// otherwise found and both coordinates are 0 and nothing is marked. After reset the bitmap
// is cleared row by row before the first request is taken. A request that is rejected
// outright goes from accept straight to result hand-off; any other request streams bitmap
// rows from the single read port one per cycle through the doubling stages to find the
// origin or exhaust the grid, then marks a found rectangle row by row and hands off the result
// once the output register is free. Requests are handled one at a time; a new one is taken
// while the previous result waits on the master side.
module first_fit_rect_allocator_unit import ffra_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [DIM_W-1:0]       cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [6:0] rect_rows, [13:7] rect_cols
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [0] found, [6:1] origin_row, [12:7] origin_col
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  ctrl_cmd_t        cmd;
  ctrl_stat_t       stat;
  logic             found;
  logic [POS_W-1:0] origin_row, origin_col;

  assign cfg_ready_o = 1'b1;

  ffra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  ffra_dp #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .rect_rows_i  (s_axis_tdata[DIM_W-1:0]),
    .rect_cols_i  (s_axis_tdata[2*DIM_W-1:DIM_W]),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .found_o      (found),
    .origin_row_o (origin_row),
    .origin_col_o (origin_col)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - 1 - 2*POS_W)'(0), origin_col, origin_row, found};

endmodule

// ----- hw/rtl/ffra_ctrl.sv -----
module ffra_ctrl import ffra_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ctrl_cmd_t  cmd_o,
  input  ctrl_stat_t stat_i
);

  state_e state_q, state_d;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cmd_o.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (stat_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = stat_i.reject ? ST_DONE : ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.hit) begin
          state_d = ST_MARK;
        end else if (stat_i.scan_done) begin
          state_d = ST_DONE;
        end
      end
      ST_MARK: begin
        if (stat_i.mark_done) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clear = 1'b1;
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_SCAN: begin
        cmd_o.scan      = 1'b1;
        cmd_o.mark_load = stat_i.hit;
      end
      ST_MARK: cmd_o.mark = 1'b1;
      ST_DONE: cmd_o.out_load = out_free;
      default: cmd_o = '0;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/ffra_dp.sv -----
module ffra_dp import ffra_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic [DIM_W-1:0]     rect_rows_i,
  input  logic [DIM_W-1:0]     rect_cols_i,
  input  ctrl_cmd_t            cmd_i,
  output ctrl_stat_t           stat_o,
  output logic                 found_o,
  output logic [POS_W-1:0]     origin_row_o,
  output logic [POS_W-1:0]     origin_col_o
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  // doubling stages: stage j checks runs of 2**j free columns while j <= k, later stages pass through
  localparam int NS = $clog2(MAX_COLS + 1);
  localparam int KW = $clog2(NS + 1);

  // configuration
  logic [DIM_W-1:0] grid_rows_q, grid_cols_q;
  logic [DIM_W-1:0] eff_rows, eff_cols;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_rows_q <= GRID_RESET;
      grid_cols_q <= GRID_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GRID_ROWS: grid_rows_q <= cfg_data_i;
        REG_GRID_COLS: grid_cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign eff_rows = (int'(grid_rows_q) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : grid_rows_q;
  assign eff_cols = (int'(grid_cols_q) > MAX_COLS) ? DIM_W'(MAX_COLS) : grid_cols_q;

  // request decode: w = 2**k + d
  logic [KW-1:0]    k_in;
  logic [DIM_W-1:0] d_in;

  always_comb begin
    int kk;
    kk = 0;
    for (int i = 0; i < DIM_W; i++) begin
      if (rect_cols_i[i]) kk = i;
    end
    k_in = KW'(kk);
    d_in = rect_cols_i - DIM_W'(1 << kk);
  end

  logic [DIM_W-1:0] h_q, w_q, rows_q, cols_q, d_q;
  logic [KW-1:0]    k_q;

  // bitmap memory
  logic [MAX_COLS-1:0] mem_q [MAX_ROWS];
  logic [MAX_COLS-1:0] rdata_q;
  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [MAX_COLS-1:0] mem_wdata;

  // control state
  logic [AW-1:0]    clr_q;
  logic [DIM_W-1:0] rd_q, ry_q;
  logic             rv_q;
  logic [NS:0]      sv_q;
  logic             hit_q;
  logic [DIM_W-1:0] mk_q, mleft_q, waddr_q;
  logic             wv_q;

  // scan pipeline payload
  logic [DIM_W-1:0]    cnt_q [MAX_COLS];
  logic [DIM_W-1:0]    cnt_d [MAX_COLS];
  logic [MAX_COLS-1:0] v_new;
  logic [MAX_COLS-1:0] s_q  [NS+1];
  logic [DIM_W-1:0]    sy_q [NS+1];
  logic [MAX_COLS-1:0] hv;
  logic                hv_any;
  logic [DIM_W-1:0]    hv_idx;
  logic [DIM_W-1:0]    orow_q, ocol_q;
  logic [MAX_COLS-1:0] mask;

  logic scan_issue, mark_issue, final_hit;

  assign scan_issue = cmd_i.scan && !hit_q && (rd_q < rows_q);
  assign mark_issue = cmd_i.mark && (mleft_q != '0);
  assign final_hit  = cmd_i.scan && sv_q[NS] && hv_any && !hit_q;

  // per column count of free rows ending at the row just read, saturating at h
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      if (rdata_q[c]) begin
        cnt_d[c] = '0;
      end else if (cnt_q[c] == h_q) begin
        cnt_d[c] = h_q;
      end else begin
        cnt_d[c] = cnt_q[c] + 1'b1;
      end
      v_new[c] = (cnt_d[c] == h_q) && (c < int'(cols_q));
    end
  end

  // run of w ones at c: two overlapping runs of 2**k at c and c + d
  assign hv = s_q[NS] & (s_q[NS] >> d_q);

  always_comb begin
    hv_any = |hv;
    hv_idx = '0;
    for (int i = MAX_COLS - 1; i >= 0; i--) begin
      if (hv[i]) hv_idx = DIM_W'(i);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_COLS; i++) begin
      mask[i] = (i >= int'(ocol_q)) && (i < int'(ocol_q) + int'(w_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      rd_q    <= '0;
      rv_q    <= 1'b0;
      sv_q    <= '0;
      hit_q   <= 1'b0;
      mk_q    <= '0;
      mleft_q <= '0;
      wv_q    <= 1'b0;
    end else begin
      if (cmd_i.clear) clr_q <= clr_q + 1'b1;
      if (cmd_i.load) begin
        rd_q  <= '0;
        rv_q  <= 1'b0;
        sv_q  <= '0;
        hit_q <= 1'b0;
      end else begin
        rv_q    <= scan_issue;
        sv_q[0] <= rv_q;
        for (int j = 1; j <= NS; j++) begin
          sv_q[j] <= sv_q[j-1];
        end
        if (scan_issue) rd_q <= rd_q + 1'b1;
        if (final_hit) hit_q <= 1'b1;
      end
      if (cmd_i.mark_load) begin
        mk_q    <= orow_q;
        mleft_q <= h_q;
      end else if (mark_issue) begin
        mk_q    <= mk_q + 1'b1;
        mleft_q <= mleft_q - 1'b1;
      end
      wv_q <= mark_issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      h_q    <= rect_rows_i;
      w_q    <= rect_cols_i;
      rows_q <= eff_rows;
      cols_q <= eff_cols;
      k_q    <= k_in;
      d_q    <= d_in;
      for (int c = 0; c < MAX_COLS; c++) begin
        cnt_q[c] <= '0;
      end
    end else if (rv_q) begin
      for (int c = 0; c < MAX_COLS; c++) begin
        cnt_q[c] <= cnt_d[c];
      end
    end
    if (scan_issue) ry_q <= rd_q;
    s_q[0]  <= v_new;
    sy_q[0] <= ry_q;
    for (int j = 1; j <= NS; j++) begin
      s_q[j]  <= (j <= int'(k_q)) ? (s_q[j-1] & (s_q[j-1] >> (1 << (j - 1)))) : s_q[j-1];
      sy_q[j] <= sy_q[j-1];
    end
    if (final_hit) begin
      orow_q <= sy_q[NS] - h_q + 1'b1;
      ocol_q <= hv_idx;
    end
    if (mark_issue) waddr_q <= mk_q;
    if (cmd_i.out_load) begin
      found_o      <= hit_q;
      origin_row_o <= hit_q ? orow_q[POS_W-1:0] : '0;
      origin_col_o <= hit_q ? ocol_q[POS_W-1:0] : '0;
    end
  end

  // clear pass writes zeros, marking does read-modify-write one row a cycle
  assign mem_we    = cmd_i.clear || wv_q;
  assign mem_waddr = cmd_i.clear ? clr_q : AW'(waddr_q);
  assign mem_wdata = cmd_i.clear ? '0 : (rdata_q | mask);
  assign mem_re    = scan_issue || mark_issue;
  assign mem_raddr = scan_issue ? AW'(rd_q) : AW'(mk_q);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem_q[mem_raddr];
  end

  always_comb begin
    stat_o            = '0;
    stat_o.clear_last = (clr_q == AW'(MAX_ROWS - 1));
    stat_o.reject     = (rect_rows_i == '0) || (rect_cols_i == '0) ||
                        (rect_rows_i > eff_rows) || (rect_cols_i > eff_cols);
    stat_o.hit        = hit_q;
    stat_o.scan_done  = !hit_q && (rd_q >= rows_q) && !rv_q && (sv_q == '0);
    stat_o.mark_done  = (mleft_q == '0) && !wv_q;
  end

endmodule

// ----- tb/first_fit_rect_allocator_checker.sv -----
`timescale 1ns / 100ps

module first_fit_rect_allocator_checker import ffra_pkg::*; #(
  parameter int MAX_ROWS = DEF_MAX_ROWS,
  parameter int MAX_COLS = DEF_MAX_COLS
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  input  logic                   cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [DIM_W-1:0]       cfg_data_i,
  input  logic                   req_valid_i,
  input  logic                   req_ready_i,
  input  logic [IN_TDATA_W-1:0]  req_data_i,
  input  logic                   rsp_valid_i,
  input  logic                   rsp_ready_i,
  input  logic [OUT_TDATA_W-1:0] rsp_data_i,
  output int                     mismatches_o,
  output int                     outstanding_o
);

  // request fields, lowest bit first: rect_rows, rect_cols
  typedef struct packed {
    logic [1:0]       pad;
    logic [DIM_W-1:0] cols;
    logic [DIM_W-1:0] rows;
  } rect_req_t;

  // result fields, lowest bit first: found, origin_row, origin_col
  typedef struct packed {
    logic [2:0]       pad;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             found;
  } placement_t;

  logic [63:0]      occupied [MAX_ROWS];
  logic [DIM_W-1:0] grid_rows_q;
  logic [DIM_W-1:0] grid_cols_q;
  placement_t       placements_q[$];
  int               mismatch_cnt;

  // first-fit search over the shadow bitmap; marks the cells on a hit
  function automatic placement_t place_rect(input logic [DIM_W-1:0] h,
                                            input logic [DIM_W-1:0] w);
    placement_t  res;
    int          rows, cols, r, c, y;
    logic [63:0] band, span;
    res  = '0;
    rows = (grid_rows_q > MAX_ROWS) ? MAX_ROWS : int'(grid_rows_q);
    cols = (grid_cols_q > MAX_COLS) ? MAX_COLS : int'(grid_cols_q);
    if (h == 0 || w == 0 || int'(h) > rows || int'(w) > cols) return res;
    for (r = 0; r + int'(h) <= rows; r++) begin
      band = '0;
      for (y = r; y < r + int'(h); y++) band |= occupied[y];
      for (c = 0; c + int'(w) <= cols; c++) begin
        span = ((w >= 64) ? '1 : ((64'd1 << w) - 64'd1)) << c;
        if ((band & span) == '0) begin
          for (y = r; y < r + int'(h); y++) occupied[y] |= span;
          res.found = 1'b1;
          res.row   = r[POS_W-1:0];
          res.col   = c[POS_W-1:0];
          return res;
        end
      end
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    placement_t exp_res, got;
    rect_req_t  req;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ROWS; i++) occupied[i] = '0;
      grid_rows_q = GRID_RESET;
      grid_cols_q = GRID_RESET;
      placements_q.delete();
      mismatch_cnt = 0;
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_GRID_ROWS: grid_rows_q = cfg_data_i;
          REG_GRID_COLS: grid_cols_q = cfg_data_i;
          default: ;
        endcase
      end
      if (rsp_valid_i && rsp_ready_i) begin
        got = placement_t'(rsp_data_i);
        if (placements_q.size() == 0) begin
          if (mismatch_cnt < 10)
            $display("%0t: result with no request pending: found=%0d row=%0d col=%0d",
                     $realtime, got.found, got.row, got.col);
          mismatch_cnt++;
        end else begin
          exp_res = placements_q.pop_front();
          if (got.found !== exp_res.found || got.row !== exp_res.row ||
              got.col !== exp_res.col) begin
            if (mismatch_cnt < 10)
              $display("%0t: exp found=%0d row=%0d col=%0d got found=%0d row=%0d col=%0d",
                       $realtime, exp_res.found, exp_res.row, exp_res.col,
                       got.found, got.row, got.col);
            mismatch_cnt++;
          end
        end
      end
      if (req_valid_i && req_ready_i) begin
        req = rect_req_t'(req_data_i);
        placements_q.push_back(place_rect(req.rows, req.cols));
      end
      mismatches_o  <= mismatch_cnt;
      outstanding_o <= placements_q.size();
    end
  end

endmodule

// ----- tb/tb_first_fit_rect_allocator_unit.sv -----
`timescale 1ns / 100ps

module tb_first_fit_rect_allocator_unit;
  import ffra_pkg::*;

  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 64;
  localparam int STALL_LIMIT   = 40000;
  localparam int RAND_PHASES   = 16;
  localparam int PHASE_ITEMS   = 115;

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = REG_GRID_ROWS;
  logic [DIM_W-1:0]       cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  // [6:0] rect_rows, [13:7] rect_cols
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // [0] found, [6:1] origin_row, [12:7] origin_col
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  int mismatches;
  int outstanding;
  int send_idle_pct = 0;
  int sink_stall_pct = 0;
  int quiet_cycles = 0;

  always #4 clk_i = ~clk_i;

  first_fit_rect_allocator_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  first_fit_rect_allocator_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .req_valid_i   (s_axis_tvalid),
    .req_ready_i   (s_axis_tready),
    .req_data_i    (s_axis_tdata),
    .rsp_valid_i   (m_axis_tvalid),
    .rsp_ready_i   (m_axis_tready),
    .rsp_data_i    (m_axis_tdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("tb_first_fit_rect_allocator_unit failed");
    $finish;
  end

  task automatic set_idling(input idle_mode_e mode);
    case (mode)
      IDLE_NONE:   begin send_idle_pct = 0;  sink_stall_pct = 0;  end
      IDLE_SENDER: begin send_idle_pct = 78; sink_stall_pct = 0;  end
      IDLE_SINK:   begin send_idle_pct = 0;  sink_stall_pct = 78; end
      default:     begin send_idle_pct = 14; sink_stall_pct = 14; end
    endcase
  endtask

  // valid stays high between back-to-back requests; it drops only for a gap or in drain
  task automatic send_rect(input logic [DIM_W-1:0] h, input logic [DIM_W-1:0] w);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, w, h};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // hold off until every placement has come back and the block is quiet
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_grid(input logic [DIM_W-1:0] rows, input logic [DIM_W-1:0] cols);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_GRID_ROWS;
    cfg_data_i  <= rows;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= REG_GRID_COLS;
    cfg_data_i  <= cols;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // mostly small rectangles so the bitmap fills slowly and scans stay short
  task automatic pick_rect(input int span_r, input int span_c,
                           output logic [DIM_W-1:0] h, output logic [DIM_W-1:0] w);
    int sel;
    sel = $urandom_range(99);
    if (sel < 70) begin
      h = DIM_W'($urandom_range(4, 1));
      w = DIM_W'($urandom_range(4, 1));
    end else if (sel < 85) begin
      h = DIM_W'($urandom_range(3, 1));
      w = DIM_W'($urandom_range(span_c, 1));
      if (sel < 78) begin
        h = DIM_W'($urandom_range(span_r, 1));
        w = DIM_W'($urandom_range(3, 1));
      end
    end else if (sel < 93) begin
      h = DIM_W'($urandom_range(span_r, 1));
      w = DIM_W'($urandom_range(span_c, 1));
    end else begin
      h = DIM_W'($urandom_range(127, 0));
      w = DIM_W'($urandom_range(127, 0));
    end
  endtask

  initial begin
    logic [DIM_W-1:0] h, w, g_rows, g_cols;
    int               span_r, span_c;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    set_idling(IDLE_NONE);

    // reset grid: one placement, then rejects: zero sizes and oversize, and a full grid that no longer fits
    send_rect(7'd1, 7'd1);
    send_rect(7'd0, 7'd5);
    send_rect(7'd5, 7'd0);
    send_rect(7'd0, 7'd0);
    send_rect(7'd127, 7'd127);
    send_rect(7'd65, 7'd1);
    send_rect(7'd1, 7'd65);
    send_rect(7'd64, 7'd64);
    drain();
    // no rows in the grid
    write_grid(7'd0, 7'd64);
    send_rect(7'd1, 7'd1);
    drain();
    write_grid(7'd1, 7'd1);
    send_rect(7'd1, 7'd1);
    send_rect(7'd2, 7'd1);
    drain();
    // column register saturates
    write_grid(7'd2, 7'd127);
    send_rect(7'd1, 7'd64);
    send_rect(7'd1, 7'd1);
    drain();
    // last column origin, then a rectangle that no longer fits
    write_grid(7'd3, 7'd2);
    send_rect(7'd1, 7'd1);
    send_rect(7'd1, 7'd1);
    send_rect(7'd1, 7'd1);
    send_rect(7'd3, 7'd2);
    drain();
    write_grid(7'd64, 7'd64);
    send_rect(7'd1, 7'd62);

    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      drain();
      set_idling(idle_mode_e'(phase % 4));
      span_r = (4 * (phase + 1) > 64) ? 64 : 4 * (phase + 1);
      g_rows = DIM_W'($urandom_range(span_r, 1));
      g_cols = DIM_W'($urandom_range(span_r, 1));
      case (phase)
        5:  g_rows = '0;
        9:  g_cols = '0;
        12: g_rows = 7'd1;
        14: begin g_rows = 7'd64; g_cols = 7'd64; end
        15: begin g_rows = 7'd127; g_cols = DIM_W'($urandom_range(127, 65)); end
        default: ;
      endcase
      write_grid(g_rows, g_cols);
      span_r = (g_rows == 0) ? 4 : ((g_rows > 64) ? 64 : int'(g_rows));
      span_c = (g_cols == 0) ? 4 : ((g_cols > 64) ? 64 : int'(g_cols));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pick_rect(span_r, span_c, h, w);
        send_rect(h, w);
      end
    end

    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_first_fit_rect_allocator_unit passed");
    end else begin
      $display("tb_first_fit_rect_allocator_unit failed");
    end
    $finish;
  end

endmodule
